// File: hdl/tpp_pkg.sv
// Shared types, codes and constants for the TFTP datagram parser.
package tpp_pkg;

    // Byte role tags
    localparam logic [3:0] ROLE_OPCODE     = 4'd0;
    localparam logic [3:0] ROLE_NUMBER     = 4'd1;
    localparam logic [3:0] ROLE_FILENAME   = 4'd2;
    localparam logic [3:0] ROLE_MODE       = 4'd3;
    localparam logic [3:0] ROLE_OPT_NAME   = 4'd4;
    localparam logic [3:0] ROLE_OPT_VALUE  = 4'd5;
    localparam logic [3:0] ROLE_PAYLOAD    = 4'd6;
    localparam logic [3:0] ROLE_MESSAGE    = 4'd7;
    localparam logic [3:0] ROLE_TERMINATOR = 4'd8;
    localparam logic [3:0] ROLE_IGNORED    = 4'd9;

    // Verdict status codes
    localparam logic [3:0] STAT_OK              = 4'd0;
    localparam logic [3:0] STAT_SHORT_OPCODE    = 4'd1;
    localparam logic [3:0] STAT_UNKNOWN_OPCODE  = 4'd2;
    localparam logic [3:0] STAT_SHORT_DATA      = 4'd3;
    localparam logic [3:0] STAT_SHORT_ACK       = 4'd4;
    localparam logic [3:0] STAT_SHORT_ERROR     = 4'd5;
    localparam logic [3:0] STAT_FILE_OPEN       = 4'd6;
    localparam logic [3:0] STAT_MODE_OPEN       = 4'd7;
    localparam logic [3:0] STAT_NAME_OPEN       = 4'd8;
    localparam logic [3:0] STAT_VALUE_OPEN      = 4'd9;
    localparam logic [3:0] STAT_EMPTY_NAME      = 4'd10;
    localparam logic [3:0] STAT_MSG_OPEN        = 4'd11;

    // Opcodes
    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    // Header byte counts
    localparam logic [2:0] HDR_NONE      = 3'd0;
    localparam logic [2:0] HDR_OP_HI     = 3'd1;
    localparam logic [2:0] HDR_OPCODE    = 3'd2;
    localparam logic [2:0] HDR_NUM_HI    = 3'd3;
    localparam logic [2:0] HDR_FULL      = 3'd4;

    localparam logic [7:0] NUL_BYTE      = 8'h00;
    localparam logic [7:0] PAIR_MAX      = 8'hFF;

    typedef enum logic [10:0] {
        PH_OPHI    = 11'b000_0000_0001,
        PH_OPLO    = 11'b000_0000_0010,
        PH_NUMHI   = 11'b000_0000_0100,
        PH_NUMLO   = 11'b000_0000_1000,
        PH_PAYLOAD = 11'b000_0001_0000,
        PH_FILE    = 11'b000_0010_0000,
        PH_MODE    = 11'b000_0100_0000,
        PH_NAME    = 11'b000_1000_0000,
        PH_VALUE   = 11'b001_0000_0000,
        PH_MSG     = 11'b010_0000_0000,
        PH_IGNORE  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_datagram;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  byte_role;
        logic        verdict_valid;
        logic [3:0]  status;
        logic [15:0] opcode_seen;
        logic [15:0] number_field;
        logic [7:0]  option_count;
    } out_item_t;

endpackage

// File: hdl/tftp_packet_parser_top.sv
// TFTP datagram parser: byte role tagging and end-of-datagram verdict.
// A byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless the result is stalled; the parse state and
// the role/verdict logic sit between the input register and the result register.
// Reset: rst_n clears the pipeline valids and the parse state to "opcode high
// byte expected"; the state also returns there after every end-of-datagram byte.
module tftp_packet_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tpp_pkg::in_item_t  byte_data,
    output logic               result_valid,
    input  logic               result_ready,
    output tpp_pkg::out_item_t result_data
);

    // Pipeline registers
    logic                s1_valid_reg;
    tpp_pkg::in_item_t   s1_data_reg;
    logic                out_valid_reg;
    tpp_pkg::out_item_t  out_data_reg;

    // Parse state
    tpp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]     opcode_reg, opcode_next;
    logic [15:0]     number_reg, number_next;
    logic            name_empty_reg, name_empty_next;
    logic [3:0]      failure_reg, failure_next;
    logic [7:0]      pair_cnt_reg, pair_cnt_next;

    // Values after this byte, before the end-of-datagram clear
    tpp_pkg::phase_t ph_a;
    logic [2:0]      hdr_a;
    logic [15:0]     op_a, num_a;
    logic            ne_a;
    logic [3:0]      fail_a;
    logic [7:0]      pc_a;
    logic [3:0]      role;
    logic [3:0]      status;
    logic [7:0]      b;
    logic            is_nul;
    logic            advance;
    logic            op_num_kind;
    tpp_pkg::out_item_t result_next;

    assign advance    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !s1_valid_reg || advance;

    assign b      = s1_data_reg.byte_value;
    assign is_nul = (b == tpp_pkg::NUL_BYTE);

    always_comb
    begin
        ph_a   = phase_reg;
        hdr_a  = hdr_cnt_reg;
        op_a   = opcode_reg;
        num_a  = number_reg;
        ne_a   = name_empty_reg;
        fail_a = failure_reg;
        pc_a   = pair_cnt_reg;
        role   = tpp_pkg::ROLE_IGNORED;

        case (phase_reg)
            tpp_pkg::PH_OPHI:
            begin
                role  = tpp_pkg::ROLE_OPCODE;
                op_a  = {b, 8'h00};
                hdr_a = tpp_pkg::HDR_OP_HI;
                ph_a  = tpp_pkg::PH_OPLO;
            end
            tpp_pkg::PH_OPLO:
            begin
                role  = tpp_pkg::ROLE_OPCODE;
                op_a  = {opcode_reg[15:8], b};
                hdr_a = tpp_pkg::HDR_OPCODE;
                if (op_a == tpp_pkg::OP_RRQ || op_a == tpp_pkg::OP_WRQ)
                begin
                    ph_a = tpp_pkg::PH_FILE;
                end
                else if (op_a == tpp_pkg::OP_DATA || op_a == tpp_pkg::OP_ACK ||
                         op_a == tpp_pkg::OP_ERROR)
                begin
                    ph_a = tpp_pkg::PH_NUMHI;
                end
                else if (op_a == tpp_pkg::OP_OACK)
                begin
                    ph_a = tpp_pkg::PH_NAME;
                    ne_a = 1'b1;
                end
                else
                begin
                    fail_a = tpp_pkg::STAT_UNKNOWN_OPCODE;
                    ph_a   = tpp_pkg::PH_IGNORE;
                end
            end
            tpp_pkg::PH_NUMHI:
            begin
                role  = tpp_pkg::ROLE_NUMBER;
                num_a = {b, 8'h00};
                hdr_a = tpp_pkg::HDR_NUM_HI;
                ph_a  = tpp_pkg::PH_NUMLO;
            end
            tpp_pkg::PH_NUMLO:
            begin
                role  = tpp_pkg::ROLE_NUMBER;
                num_a = {number_reg[15:8], b};
                hdr_a = tpp_pkg::HDR_FULL;
                if (opcode_reg == tpp_pkg::OP_DATA)
                begin
                    ph_a = tpp_pkg::PH_PAYLOAD;
                end
                else if (opcode_reg == tpp_pkg::OP_ERROR)
                begin
                    ph_a = tpp_pkg::PH_MSG;
                end
                else
                begin
                    ph_a = tpp_pkg::PH_IGNORE;
                end
            end
            tpp_pkg::PH_PAYLOAD:
            begin
                role = tpp_pkg::ROLE_PAYLOAD;
            end
            tpp_pkg::PH_FILE:
            begin
                if (is_nul)
                begin
                    role = tpp_pkg::ROLE_TERMINATOR;
                    ph_a = tpp_pkg::PH_MODE;
                end
                else
                begin
                    role = tpp_pkg::ROLE_FILENAME;
                end
            end
            tpp_pkg::PH_MODE:
            begin
                if (is_nul)
                begin
                    role = tpp_pkg::ROLE_TERMINATOR;
                    ph_a = tpp_pkg::PH_NAME;
                    ne_a = 1'b1;
                end
                else
                begin
                    role = tpp_pkg::ROLE_MODE;
                end
            end
            tpp_pkg::PH_NAME:
            begin
                if (is_nul)
                begin
                    role = tpp_pkg::ROLE_TERMINATOR;
                    ph_a = tpp_pkg::PH_VALUE;
                end
                else
                begin
                    role = tpp_pkg::ROLE_OPT_NAME;
                    ne_a = 1'b0;
                end
            end
            tpp_pkg::PH_VALUE:
            begin
                if (is_nul)
                begin
                    role = tpp_pkg::ROLE_TERMINATOR;
                    if (name_empty_reg)
                    begin
                        fail_a = tpp_pkg::STAT_EMPTY_NAME;
                        ph_a   = tpp_pkg::PH_IGNORE;
                    end
                    else
                    begin
                        if (pair_cnt_reg != tpp_pkg::PAIR_MAX)
                        begin
                            pc_a = pair_cnt_reg + 8'd1;
                        end
                        ph_a = tpp_pkg::PH_NAME;
                        ne_a = 1'b1;
                    end
                end
                else
                begin
                    role = tpp_pkg::ROLE_OPT_VALUE;
                end
            end
            tpp_pkg::PH_MSG:
            begin
                if (is_nul)
                begin
                    role = tpp_pkg::ROLE_TERMINATOR;
                    ph_a = tpp_pkg::PH_IGNORE;
                end
                else
                begin
                    role = tpp_pkg::ROLE_MESSAGE;
                end
            end
            default:
            begin
                // ignore phase, and any illegal code
                role = tpp_pkg::ROLE_IGNORED;
            end
        endcase
    end

    assign op_num_kind = (op_a == tpp_pkg::OP_DATA) || (op_a == tpp_pkg::OP_ACK) ||
                         (op_a == tpp_pkg::OP_ERROR);

    // Verdict from the state after this byte; first failure wins
    always_comb
    begin
        status = tpp_pkg::STAT_OK;
        if (fail_a != tpp_pkg::STAT_OK)
        begin
            status = fail_a;
        end
        else
        begin
            case (ph_a)
                tpp_pkg::PH_OPLO:
                begin
                    status = tpp_pkg::STAT_SHORT_OPCODE;
                end
                tpp_pkg::PH_NUMHI, tpp_pkg::PH_NUMLO:
                begin
                    if (op_a == tpp_pkg::OP_DATA)
                    begin
                        status = tpp_pkg::STAT_SHORT_DATA;
                    end
                    else if (op_a == tpp_pkg::OP_ACK)
                    begin
                        status = tpp_pkg::STAT_SHORT_ACK;
                    end
                    else
                    begin
                        status = tpp_pkg::STAT_SHORT_ERROR;
                    end
                end
                tpp_pkg::PH_FILE:  status = tpp_pkg::STAT_FILE_OPEN;
                tpp_pkg::PH_MODE:  status = tpp_pkg::STAT_MODE_OPEN;
                tpp_pkg::PH_NAME:
                begin
                    status = ne_a ? tpp_pkg::STAT_OK : tpp_pkg::STAT_NAME_OPEN;
                end
                tpp_pkg::PH_VALUE: status = tpp_pkg::STAT_VALUE_OPEN;
                tpp_pkg::PH_MSG:   status = tpp_pkg::STAT_MSG_OPEN;
                default:           status = tpp_pkg::STAT_OK;
            endcase
        end
    end

    always_comb
    begin
        result_next              = '0;
        result_next.byte_out     = b;
        result_next.byte_role    = role;
        if (s1_data_reg.end_of_datagram)
        begin
            result_next.verdict_valid = 1'b1;
            result_next.status        = status;
            result_next.opcode_seen   = (hdr_a >= tpp_pkg::HDR_OPCODE) ? op_a : 16'h0000;
            result_next.number_field  = (hdr_a >= tpp_pkg::HDR_FULL && op_num_kind) ?
                                        num_a : 16'h0000;
            result_next.option_count  = pc_a;
        end
    end

    // Back to the start-of-datagram state after the last byte
    always_comb
    begin
        if (s1_data_reg.end_of_datagram)
        begin
            phase_next      = tpp_pkg::PH_OPHI;
            hdr_cnt_next    = tpp_pkg::HDR_NONE;
            opcode_next     = 16'h0000;
            number_next     = 16'h0000;
            name_empty_next = 1'b1;
            failure_next    = tpp_pkg::STAT_OK;
            pair_cnt_next   = 8'h00;
        end
        else
        begin
            phase_next      = ph_a;
            hdr_cnt_next    = hdr_a;
            opcode_next     = op_a;
            number_next     = num_a;
            name_empty_next = ne_a;
            failure_next    = fail_a;
            pair_cnt_next   = pc_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= tpp_pkg::PH_OPHI;
            hdr_cnt_reg    <= tpp_pkg::HDR_NONE;
            opcode_reg     <= 16'h0000;
            number_reg     <= 16'h0000;
            name_empty_reg <= 1'b1;
            failure_reg    <= tpp_pkg::STAT_OK;
            pair_cnt_reg   <= 8'h00;
        end
        else
        begin
            if (byte_ready)
            begin
                s1_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                opcode_reg     <= opcode_next;
                number_reg     <= number_next;
                name_empty_reg <= name_empty_next;
                failure_reg    <= failure_next;
                pair_cnt_reg   <= pair_cnt_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            s1_data_reg <= byte_data;
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// File: hdl/tpp_checker.sv
// Port-level checks for the TFTP datagram parser, bound to the top level.
module tpp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               byte_ready,
    input logic               result_valid,
    input logic               result_ready,
    input tpp_pkg::out_item_t result_data
);

    logic result_xfer;
    assign result_xfer = result_valid && result_ready;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // verdict fields are zero on non-final bytes
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && !result_data.verdict_valid |->
            result_data.status == tpp_pkg::STAT_OK &&
            result_data.opcode_seen == 16'h0000 &&
            result_data.number_field == 16'h0000 &&
            result_data.option_count == 8'h00)
        else $error("verdict fields set without verdict");

    // an unknown-opcode verdict never carries a known opcode
    a_unknown_op: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && result_data.verdict_valid &&
        result_data.status == tpp_pkg::STAT_UNKNOWN_OPCODE |->
            result_data.opcode_seen != tpp_pkg::OP_RRQ &&
            result_data.opcode_seen != tpp_pkg::OP_WRQ &&
            result_data.opcode_seen != tpp_pkg::OP_DATA &&
            result_data.opcode_seen != tpp_pkg::OP_ACK &&
            result_data.opcode_seen != tpp_pkg::OP_ERROR &&
            result_data.opcode_seen != tpp_pkg::OP_OACK)
        else $error("unknown-opcode status with a known opcode");

    // a number field only comes with DATA, ACK or ERROR
    a_number_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && result_data.number_field != 16'h0000 |->
            result_data.opcode_seen == tpp_pkg::OP_DATA ||
            result_data.opcode_seen == tpp_pkg::OP_ACK ||
            result_data.opcode_seen == tpp_pkg::OP_ERROR)
        else $error("number field on a datagram kind without one");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> result_valid && !result_ready)
        else $error("input not ready without a stalled result");

endmodule

bind tftp_packet_parser_top tpp_checker u_tpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// File: tb/tpp_result_checker.sv
// Checker for the TFTP datagram parser: predicts each byte's result and compares transfers.
module tpp_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  tpp_pkg::in_item_t   byte_data,
    input  logic                result_valid,
    input  logic                result_ready,
    input  tpp_pkg::out_item_t  result_data,
    output int                  mismatch_count,
    output int                  results_owed
);

    // Parser state mirror
    tpp_pkg::phase_t phase;
    logic [2:0]      hdr_seen;
    logic [15:0]     opcode_val;
    logic [15:0]     number_val;
    logic            name_empty;
    logic [3:0]      first_fail;
    logic [7:0]      pair_count;

    tpp_pkg::out_item_t expected_results[$];
    tpp_pkg::out_item_t want;

    function automatic void clear_parser();
        phase      = tpp_pkg::PH_OPHI;
        hdr_seen   = tpp_pkg::HDR_NONE;
        opcode_val = '0;
        number_val = '0;
        name_empty = 1'b1;
        first_fail = tpp_pkg::STAT_OK;
        pair_count = '0;
    endfunction

    function automatic void open_option_name();
        phase      = tpp_pkg::PH_NAME;
        name_empty = 1'b1;
    endfunction

    function automatic tpp_pkg::out_item_t parse_byte(input tpp_pkg::in_item_t it);
        tpp_pkg::out_item_t r;
        logic [7:0]         b;
        b = it.byte_value;
        r = '0;
        r.byte_out  = b;
        r.byte_role = tpp_pkg::ROLE_IGNORED;
        case (phase)
            tpp_pkg::PH_OPHI:
            begin
                r.byte_role = tpp_pkg::ROLE_OPCODE;
                opcode_val  = {b, 8'h00};
                hdr_seen    = tpp_pkg::HDR_OP_HI;
                phase       = tpp_pkg::PH_OPLO;
            end
            tpp_pkg::PH_OPLO:
            begin
                r.byte_role = tpp_pkg::ROLE_OPCODE;
                opcode_val  = opcode_val | {8'h00, b};
                hdr_seen    = tpp_pkg::HDR_OPCODE;
                if (opcode_val == tpp_pkg::OP_RRQ || opcode_val == tpp_pkg::OP_WRQ)
                    phase = tpp_pkg::PH_FILE;
                else if (opcode_val >= tpp_pkg::OP_DATA && opcode_val <= tpp_pkg::OP_ERROR)
                    phase = tpp_pkg::PH_NUMHI;
                else if (opcode_val == tpp_pkg::OP_OACK)
                    open_option_name();
                else
                begin
                    first_fail = tpp_pkg::STAT_UNKNOWN_OPCODE;
                    phase      = tpp_pkg::PH_IGNORE;
                end
            end
            tpp_pkg::PH_NUMHI:
            begin
                r.byte_role = tpp_pkg::ROLE_NUMBER;
                number_val  = {b, 8'h00};
                hdr_seen    = tpp_pkg::HDR_NUM_HI;
                phase       = tpp_pkg::PH_NUMLO;
            end
            tpp_pkg::PH_NUMLO:
            begin
                r.byte_role = tpp_pkg::ROLE_NUMBER;
                number_val  = number_val | {8'h00, b};
                hdr_seen    = tpp_pkg::HDR_FULL;
                if (opcode_val == tpp_pkg::OP_DATA)
                    phase = tpp_pkg::PH_PAYLOAD;
                else if (opcode_val == tpp_pkg::OP_ERROR)
                    phase = tpp_pkg::PH_MSG;
                else
                    phase = tpp_pkg::PH_IGNORE;
            end
            tpp_pkg::PH_PAYLOAD:
                r.byte_role = tpp_pkg::ROLE_PAYLOAD;
            tpp_pkg::PH_FILE:
            begin
                if (b == tpp_pkg::NUL_BYTE)
                begin
                    r.byte_role = tpp_pkg::ROLE_TERMINATOR;
                    phase       = tpp_pkg::PH_MODE;
                end
                else
                    r.byte_role = tpp_pkg::ROLE_FILENAME;
            end
            tpp_pkg::PH_MODE:
            begin
                if (b == tpp_pkg::NUL_BYTE)
                begin
                    r.byte_role = tpp_pkg::ROLE_TERMINATOR;
                    open_option_name();
                end
                else
                    r.byte_role = tpp_pkg::ROLE_MODE;
            end
            tpp_pkg::PH_NAME:
            begin
                if (b == tpp_pkg::NUL_BYTE)
                begin
                    r.byte_role = tpp_pkg::ROLE_TERMINATOR;
                    phase       = tpp_pkg::PH_VALUE;
                end
                else
                begin
                    r.byte_role = tpp_pkg::ROLE_OPT_NAME;
                    name_empty  = 1'b0;
                end
            end
            tpp_pkg::PH_VALUE:
            begin
                if (b == tpp_pkg::NUL_BYTE)
                begin
                    r.byte_role = tpp_pkg::ROLE_TERMINATOR;
                    // empty name is only flagged once its value closes
                    if (name_empty)
                    begin
                        first_fail = tpp_pkg::STAT_EMPTY_NAME;
                        phase      = tpp_pkg::PH_IGNORE;
                    end
                    else
                    begin
                        if (pair_count != tpp_pkg::PAIR_MAX)
                            pair_count = pair_count + 8'd1;
                        open_option_name();
                    end
                end
                else
                    r.byte_role = tpp_pkg::ROLE_OPT_VALUE;
            end
            tpp_pkg::PH_MSG:
            begin
                if (b == tpp_pkg::NUL_BYTE)
                begin
                    r.byte_role = tpp_pkg::ROLE_TERMINATOR;
                    phase       = tpp_pkg::PH_IGNORE;
                end
                else
                    r.byte_role = tpp_pkg::ROLE_MESSAGE;
            end
            default:
                r.byte_role = tpp_pkg::ROLE_IGNORED;
        endcase

        if (it.end_of_datagram)
        begin
            r.verdict_valid = 1'b1;
            if (first_fail != tpp_pkg::STAT_OK)
                r.status = first_fail;
            else
            begin
                case (phase)
                    tpp_pkg::PH_OPLO:  r.status = tpp_pkg::STAT_SHORT_OPCODE;
                    tpp_pkg::PH_NUMHI, tpp_pkg::PH_NUMLO:
                        r.status = (opcode_val == tpp_pkg::OP_DATA) ?
                                       tpp_pkg::STAT_SHORT_DATA :
                                   (opcode_val == tpp_pkg::OP_ACK) ?
                                       tpp_pkg::STAT_SHORT_ACK :
                                       tpp_pkg::STAT_SHORT_ERROR;
                    tpp_pkg::PH_FILE:  r.status = tpp_pkg::STAT_FILE_OPEN;
                    tpp_pkg::PH_MODE:  r.status = tpp_pkg::STAT_MODE_OPEN;
                    tpp_pkg::PH_NAME:
                        r.status = name_empty ? tpp_pkg::STAT_OK : tpp_pkg::STAT_NAME_OPEN;
                    tpp_pkg::PH_VALUE: r.status = tpp_pkg::STAT_VALUE_OPEN;
                    tpp_pkg::PH_MSG:   r.status = tpp_pkg::STAT_MSG_OPEN;
                    default:           r.status = tpp_pkg::STAT_OK;
                endcase
            end
            r.opcode_seen  = (hdr_seen >= tpp_pkg::HDR_OPCODE) ? opcode_val : 16'h0000;
            r.number_field = (hdr_seen >= tpp_pkg::HDR_FULL &&
                              opcode_val >= tpp_pkg::OP_DATA &&
                              opcode_val <= tpp_pkg::OP_ERROR) ? number_val : 16'h0000;
            r.option_count = pair_count;
            clear_parser();
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t checker: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            results_owed   = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t checker: unexpected result, expected none, actual 0x%0h",
                             $time, result_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("byte_out", 16'(want.byte_out),
                                16'(result_data.byte_out));
                    check_field("byte_role", 16'(want.byte_role),
                                16'(result_data.byte_role));
                    check_field("verdict_valid", 16'(want.verdict_valid),
                                16'(result_data.verdict_valid));
                    check_field("status", 16'(want.status),
                                16'(result_data.status));
                    check_field("opcode_seen", want.opcode_seen, result_data.opcode_seen);
                    check_field("number_field", want.number_field,
                                result_data.number_field);
                    check_field("option_count", 16'(want.option_count),
                                16'(result_data.option_count));
                end
            end
            if (byte_valid && byte_ready)
                expected_results.insert(expected_results.size(), parse_byte(byte_data));
            results_owed = expected_results.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the TFTP parser testbench: clock, reset, datagram stimulus and the verdict.
module testbench;

    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  PHASE_BYTES  = 200;
    localparam int  SETTLE_TICKS = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               byte_valid   = 1'b0;
    logic               byte_ready;
    tpp_pkg::in_item_t  byte_data    = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    tpp_pkg::out_item_t result_data;

    int mismatch_count;
    int results_owed;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int datagrams_sent = 0;
    int src_idle       = 0;
    int sink_stall     = 0;

    logic [7:0] dgram[$];

    always #6 clk = ~clk;

    tftp_packet_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    tpp_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_data      (byte_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= sink_stall);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: timeout at cycle %0d, %0d results still owed",
                     cycle_count, results_owed);
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input tpp_pkg::in_item_t it);
        while ($urandom_range(0, 99) < src_idle)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_datagram();
        tpp_pkg::in_item_t it;
        for (int i = 0; i < dgram.size(); i++)
        begin
            it.byte_value      = dgram[i];
            it.end_of_datagram = (i == dgram.size() - 1);
            send_byte(it);
        end
        datagrams_sent++;
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_drained();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic append_byte(input logic [7:0] v);
        dgram.insert(dgram.size(), v);
    endtask

    task automatic start_datagram(input logic [15:0] op);
        dgram.delete();
        append_byte(op[15:8]);
        append_byte(op[7:0]);
    endtask

    task automatic push_number(input logic [15:0] num);
        append_byte(num[15:8]);
        append_byte(num[7:0]);
    endtask

    // NUL-terminated string of nonzero characters
    task automatic add_text(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) append_byte(8'($urandom_range(1, 255)));
        append_byte(tpp_pkg::NUL_BYTE);
    endtask

    task automatic add_raw(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_pairs();
        int n;
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                add_text(0, 0);
            else
                add_text(1, 5);
            add_text(0, 5);
        end
    endtask

    task automatic build_datagram();
        int          kind;
        int          cut;
        logic [15:0] op;
        logic [15:0] num;
        dgram.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 82)
        begin
            add_raw(1, 10);
            return;
        end
        if (kind < 20)
            op = $urandom_range(0, 1) ? tpp_pkg::OP_WRQ : tpp_pkg::OP_RRQ;
        else if (kind < 34)
            op = tpp_pkg::OP_OACK;
        else if (kind < 48)
            op = tpp_pkg::OP_DATA;
        else if (kind < 58)
            op = tpp_pkg::OP_ACK;
        else if (kind < 70)
            op = tpp_pkg::OP_ERROR;
        else if ($urandom_range(0, 3) == 0)
            op = 16'h0000;
        else
        begin
            do
                op = 16'($urandom_range(0, 65535));
            while (op >= tpp_pkg::OP_RRQ && op <= tpp_pkg::OP_OACK);
        end
        start_datagram(op);
        case (op)
            tpp_pkg::OP_RRQ, tpp_pkg::OP_WRQ:
            begin
                add_text(0, 8);
                add_text(0, 6);
                add_pairs();
            end
            tpp_pkg::OP_OACK:
                add_pairs();
            tpp_pkg::OP_DATA, tpp_pkg::OP_ACK, tpp_pkg::OP_ERROR:
            begin
                case ($urandom_range(0, 7))
                    0:       num = 16'h0000;
                    1:       num = 16'hFFFF;
                    default: num = 16'($urandom_range(0, 65535));
                endcase
                push_number(num);
                if (op == tpp_pkg::OP_DATA)
                    add_raw(0, 12);
                else if (op == tpp_pkg::OP_ACK)
                    add_raw(0, 3);
                else
                begin
                    add_text(0, 8);
                    add_raw(0, 3);
                end
            end
            default:
                add_raw(0, 4);
        endcase
        // a quarter of the structured datagrams are cut to a random length
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, dgram.size());
            while (dgram.size() > cut)
                void'(dgram.pop_back());
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed datagrams
        dgram.delete();
        append_byte(8'hFF);
        send_datagram();                       // lone byte, opcode cut short
        start_datagram(16'hFFFF);
        append_byte(8'h80);
        send_datagram();                       // unknown opcode, rest ignored
        start_datagram(tpp_pkg::OP_ACK);
        push_number(16'hFFFF);
        append_byte(8'h55);
        send_datagram();                       // ACK with trailing byte
        start_datagram(tpp_pkg::OP_ERROR);
        push_number(16'h0001);
        append_byte(tpp_pkg::NUL_BYTE);
        append_byte(8'h7E);
        send_datagram();                       // ERROR, empty message, trailing byte
        start_datagram(tpp_pkg::OP_OACK);
        append_byte(tpp_pkg::NUL_BYTE);
        append_byte(8'h78);
        append_byte(tpp_pkg::NUL_BYTE);
        send_datagram();                       // empty option name
        start_datagram(tpp_pkg::OP_WRQ);
        append_byte(tpp_pkg::NUL_BYTE);
        append_byte(tpp_pkg::NUL_BYTE);
        append_byte(tpp_pkg::NUL_BYTE);
        append_byte(8'h41);
        send_datagram();                       // empty name, value left open
        start_datagram(tpp_pkg::OP_DATA);
        push_number(16'hFF00);
        send_datagram();                       // DATA, header only

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    src_idle   = 0;
                    sink_stall = 0;
                end
                1:
                begin
                    src_idle   = 68;
                    sink_stall = 0;
                end
                2:
                begin
                    src_idle   = 0;
                    sink_stall = 68;
                end
                default:
                begin
                    src_idle   = 31;
                    sink_stall = 31;
                end
            endcase
            if (p == 0)
            begin
                // enough pairs to pin the option count at its ceiling
                start_datagram(tpp_pkg::OP_OACK);
                repeat (257)
                begin
                    append_byte(8'h61);
                    append_byte(tpp_pkg::NUL_BYTE);
                    append_byte(tpp_pkg::NUL_BYTE);
                end
                send_datagram();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 99) < 3)
                    wait_drained();
                build_datagram();
                send_datagram();
            end
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(negedge clk);
        $display("testbench: %0d bytes in %0d datagrams over every opcode kind,",
                 bytes_sent, datagrams_sent);
        $display("testbench: truncated and noisy datagrams, four idle/stall mixes");
        if (mismatch_count == 0 && results_owed == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: tftp_packet_parser_top.f
hdl/tpp_pkg.sv
hdl/tftp_packet_parser_top.sv
hdl/tpp_checker.sv
tb/tpp_result_checker.sv
tb/testbench.sv
